>>> sv/mlf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlf_pkg;

   localparam int STATION_SLOTS = 64;
   localparam int PEER_SLOTS    = 8;
   localparam int MAX_SLOTS     = (STATION_SLOTS > PEER_SLOTS) ? STATION_SLOTS : PEER_SLOTS;

   localparam int SIDX_W  = (STATION_SLOTS > 1) ? $clog2(STATION_SLOTS) : 1;
   localparam int PIDX_W  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int CNT_W   = $clog2(MAX_SLOTS + 1);

   localparam int MAC_W   = 48;
   localparam int IP_W    = 32;
   localparam int LOC_W   = 4;
   localparam int MASK_W  = 8;
   localparam int SLOT_W  = 3;
   localparam int EXT_W   = (PEER_SLOTS > MASK_W) ? PEER_SLOTS : MASK_W;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [LOC_W-1:0] LOCAL_WHERE  = 4'hF;
   localparam logic [MAC_W-1:0] BCAST_MAC    = 48'hFFFF_FFFF_FFFF;
   localparam logic [23:0]      MCAST_PREFIX = 24'h01_00_5E;

   localparam logic REG_FWD_MCAST = 1'b0;

   typedef struct packed {
      logic [MAC_W-1:0] mac;
      logic [LOC_W-1:0] loc;
   } st_entry_type;

   typedef struct packed {
      logic              en;
      logic [SIDX_W-1:0] addr;
      logic [MAC_W-1:0]  mac;
      logic [LOC_W-1:0]  loc;
   } st_wr_type;

endpackage

`default_nettype wire

>>> sv/mlf_station_table.sv
`timescale 1ns / 1ps
`default_nettype none

module mlf_station_table
   import mlf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [SIDX_W-1:0]        rd_addr,
   input  wire st_wr_type                wr,
   output st_entry_type                  rd_data,
   output logic [STATION_SLOTS-1:0]      valid
);

   st_entry_type               mem [STATION_SLOTS];
   st_entry_type               rd_data_ff;
   logic [STATION_SLOTS-1:0]   valid_ff;
   logic [STATION_SLOTS-1:0]   valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= '{mac: wr.mac, loc: wr.loc};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule

`default_nettype wire

>>> sv/mac_learning_forwarder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Search: the single comparator steps through the station memory (and first the peer memory for a
// remote request) one entry a cycle, and a search ends at the first hit or at the last entry.
// Requests: one at a time; req_stall is high while a request is worked, until its response
// is registered.
// Reset: synchronous, active high; clears both tables' valid bits and forward_multicast.

module mac_learning_forwarder_top
   import mlf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_mode,
   input  wire logic [MAC_W-1:0]    req_src_mac,
   input  wire logic [MAC_W-1:0]    req_dst_mac,
   input  wire logic [IP_W-1:0]     req_peer_addr,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [MASK_W-1:0]        rsp_forward_mask,
   output logic                     rsp_deliver_local,
   output logic                     rsp_unknown_dest,
   output logic                     rsp_station_learned,
   output logic                     rsp_station_full,
   output logic                     rsp_peer_learned,
   output logic                     rsp_peer_full,
   output logic [SLOT_W-1:0]        rsp_peer_slot,

   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [PADDR_W-1:0]  paddr,
   input  wire logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]       prdata,
   output logic                     pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PEER,
      ST_SRC,
      ST_DST,
      ST_DONE
   } state_type;

   function automatic logic [MASK_W-1:0] flood_mask(input logic [PEER_SLOTS-1:0] pv,
                                                    input logic [LOC_W-1:0] owner);
      logic [EXT_W-1:0]  pv_ext;
      logic [MASK_W-1:0] m;
      pv_ext = EXT_W'(pv);
      m = '0;
      for (int i = 0; i < MASK_W; i++) begin
         m[i] = pv_ext[i] && (owner != LOC_W'(i));
      end
      return m;
   endfunction

   function automatic logic [MASK_W-1:0] unicast_mask(input logic [LOC_W-1:0] loc);
      logic [MASK_W-1:0] m;
      m = '0;
      for (int i = 0; i < MASK_W; i++) begin
         m[i] = (loc != LOCAL_WHERE) && (loc < LOC_W'(PEER_SLOTS)) && (loc == LOC_W'(i));
      end
      return m;
   endfunction

   // control
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                free_found_ff, free_found_in;
   logic [CNT_W-1:0]    free_idx_ff, free_idx_in;
   logic                fwd_mcast_ff, fwd_mcast_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PEER_SLOTS-1:0] peer_valid_ff, peer_valid_in;

   // request context and result flags
   logic [MAC_W-1:0]    key_ff, key_in;
   logic [MAC_W-1:0]    src_ff, src_in;
   logic [MAC_W-1:0]    dst_ff, dst_in;
   logic                mode_ff, mode_in;
   logic [LOC_W-1:0]    loc_ff, loc_in;
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic                unk_ff, unk_in;
   logic                slearn_ff, slearn_in;
   logic                sfull_ff, sfull_in;
   logic                plearn_ff, plearn_in;
   logic                pfull_ff, pfull_in;
   logic [SLOT_W-1:0]   pslot_ff, pslot_in;

   // result register
   logic [MASK_W-1:0]   rsp_mask_ff, rsp_mask_in;
   logic                rsp_dlocal_ff, rsp_dlocal_in;
   logic                rsp_unk_ff, rsp_unk_in;
   logic                rsp_slearn_ff, rsp_slearn_in;
   logic                rsp_sfull_ff, rsp_sfull_in;
   logic                rsp_plearn_ff, rsp_plearn_in;
   logic                rsp_pfull_ff, rsp_pfull_in;
   logic [SLOT_W-1:0]   rsp_pslot_ff, rsp_pslot_in;

   // peer table
   logic [IP_W-1:0]     peer_ip_mem [PEER_SLOTS];
   logic [IP_W-1:0]     peer_rd_ff;
   logic                peer_wr_en;
   logic [PIDX_W-1:0]   peer_wr_idx;

   // station table
   st_entry_type              st_rd;
   logic [STATION_SLOTS-1:0]  st_valid;
   st_wr_type                 st_wr;
   logic                      st_rd_en;

   // shared compare unit
   logic                req_fire;
   logic                in_peer;
   logic                in_scan;
   logic                issue;
   logic                vld_bit;
   logic [MAC_W-1:0]    cmp_a;
   logic                eq;
   logic                hit;
   logic                last;
   logic                done_scan;
   logic                free_any;
   logic [CNT_W-1:0]    fidx;
   logic                flood;
   logic                cfg_wr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   assign in_peer = (state_ff == ST_PEER);
   assign in_scan = (state_ff == ST_PEER) || (state_ff == ST_SRC) || (state_ff == ST_DST);
   assign issue   = in_scan && (in_peer ? (cnt_ff < CNT_W'(PEER_SLOTS))
                                        : (cnt_ff < CNT_W'(STATION_SLOTS)));

   assign vld_bit = in_peer ? peer_valid_ff[cmp_idx_ff[PIDX_W-1:0]]
                            : st_valid[cmp_idx_ff[SIDX_W-1:0]];
   assign cmp_a   = in_peer ? {{(MAC_W-IP_W){1'b0}}, peer_rd_ff} : st_rd.mac;
   assign eq      = (cmp_a == key_ff);
   assign hit     = cmp_vld_ff && vld_bit && eq;
   assign last    = in_peer ? (cmp_idx_ff == CNT_W'(PEER_SLOTS - 1))
                            : (cmp_idx_ff == CNT_W'(STATION_SLOTS - 1));
   assign done_scan = cmp_vld_ff && (hit || last);
   assign free_any  = free_found_ff || !vld_bit;
   assign fidx      = free_found_ff ? free_idx_ff : cmp_idx_ff;

   assign flood = (dst_ff == BCAST_MAC) || (fwd_mcast_ff && (dst_ff[MAC_W-1:MAC_W-24] == MCAST_PREFIX));

   assign st_rd_en = issue && !in_peer;

   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = issue ? cnt_ff + 1'b1 : cnt_ff;
      cmp_vld_in    = issue;
      cmp_idx_in    = cnt_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      peer_valid_in = peer_valid_ff;
      fwd_mcast_in  = fwd_mcast_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      key_in    = key_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      mode_in   = mode_ff;
      loc_in    = loc_ff;
      mask_in   = mask_ff;
      unk_in    = unk_ff;
      slearn_in = slearn_ff;
      sfull_in  = sfull_ff;
      plearn_in = plearn_ff;
      pfull_in  = pfull_ff;
      pslot_in  = pslot_ff;

      rsp_mask_in   = rsp_mask_ff;
      rsp_dlocal_in = rsp_dlocal_ff;
      rsp_unk_in    = rsp_unk_ff;
      rsp_slearn_in = rsp_slearn_ff;
      rsp_sfull_in  = rsp_sfull_ff;
      rsp_plearn_in = rsp_plearn_ff;
      rsp_pfull_in  = rsp_pfull_ff;
      rsp_pslot_in  = rsp_pslot_ff;

      peer_wr_en  = 1'b0;
      peer_wr_idx = fidx[PIDX_W-1:0];
      st_wr.en    = 1'b0;
      st_wr.addr  = fidx[SIDX_W-1:0];
      st_wr.mac   = src_ff;
      st_wr.loc   = loc_ff;

      if (cfg_wr && (paddr[2] == REG_FWD_MCAST)) begin
         fwd_mcast_in = pwdata[0];
      end

      if (cmp_vld_ff && !vld_bit && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = cmp_idx_ff;
      end
      if (done_scan) begin
         cnt_in        = '0;
         cmp_vld_in    = 1'b0;
         free_found_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               src_in    = req_src_mac;
               dst_in    = req_dst_mac;
               mode_in   = req_mode;
               mask_in   = '0;
               unk_in    = 1'b0;
               slearn_in = 1'b0;
               sfull_in  = 1'b0;
               plearn_in = 1'b0;
               pfull_in  = 1'b0;
               pslot_in  = '0;
               if (req_mode) begin
                  key_in   = {{(MAC_W-IP_W){1'b0}}, req_peer_addr};
                  state_in = ST_PEER;
               end else begin
                  key_in   = req_src_mac;
                  loc_in   = LOCAL_WHERE;
                  state_in = ST_SRC;
               end
            end
         end
         ST_PEER: begin
            if (done_scan) begin
               if (hit) begin
                  pslot_in = SLOT_W'(cmp_idx_ff);
                  loc_in   = LOC_W'(cmp_idx_ff);
                  key_in   = src_ff;
                  state_in = ST_SRC;
               end else if (free_any) begin
                  peer_wr_en                      = 1'b1;
                  peer_valid_in[fidx[PIDX_W-1:0]] = 1'b1;
                  plearn_in = 1'b1;
                  pslot_in  = SLOT_W'(fidx);
                  loc_in    = LOC_W'(fidx);
                  key_in    = src_ff;
                  state_in  = ST_SRC;
               end else begin
                  pfull_in = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SRC: begin
            if (done_scan) begin
               if (hit) begin
                  mask_in = flood_mask(peer_valid_ff, st_rd.loc);
               end else if (free_any) begin
                  st_wr.en  = 1'b1;
                  slearn_in = 1'b1;
                  mask_in   = flood_mask(peer_valid_ff, loc_ff);
               end else begin
                  sfull_in = 1'b1;
                  mask_in  = flood_mask(peer_valid_ff, LOCAL_WHERE);
               end
               if (mode_ff || flood) begin
                  if (mode_ff) begin
                     mask_in = '0;
                  end
                  state_in = ST_DONE;
               end else begin
                  mask_in  = '0;
                  key_in   = dst_ff;
                  state_in = ST_DST;
               end
            end
         end
         ST_DST: begin
            if (done_scan) begin
               if (hit) begin
                  mask_in = unicast_mask(st_rd.loc);
               end else begin
                  unk_in = 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_mask_in   = mask_ff;
               rsp_dlocal_in = mode_ff;
               rsp_unk_in    = unk_ff;
               rsp_slearn_in = slearn_ff;
               rsp_sfull_in  = sfull_ff;
               rsp_plearn_in = plearn_ff;
               rsp_pfull_in  = pfull_ff;
               rsp_pslot_in  = pslot_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         free_found_ff <= 1'b0;
         peer_valid_ff <= '0;
         fwd_mcast_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         cmp_vld_ff    <= cmp_vld_in;
         free_found_ff <= free_found_in;
         peer_valid_ff <= peer_valid_in;
         fwd_mcast_ff  <= fwd_mcast_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmp_idx_ff    <= cmp_idx_in;
      free_idx_ff   <= free_idx_in;
      key_ff        <= key_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      mode_ff       <= mode_in;
      loc_ff        <= loc_in;
      mask_ff       <= mask_in;
      unk_ff        <= unk_in;
      slearn_ff     <= slearn_in;
      sfull_ff      <= sfull_in;
      plearn_ff     <= plearn_in;
      pfull_ff      <= pfull_in;
      pslot_ff      <= pslot_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_dlocal_ff <= rsp_dlocal_in;
      rsp_unk_ff    <= rsp_unk_in;
      rsp_slearn_ff <= rsp_slearn_in;
      rsp_sfull_ff  <= rsp_sfull_in;
      rsp_plearn_ff <= rsp_plearn_in;
      rsp_pfull_ff  <= rsp_pfull_in;
      rsp_pslot_ff  <= rsp_pslot_in;
   end

   always_ff @(posedge clock) begin
      if (peer_wr_en) begin
         peer_ip_mem[peer_wr_idx] <= key_ff[IP_W-1:0];
      end
      if (issue && in_peer) begin
         peer_rd_ff <= peer_ip_mem[cnt_ff[PIDX_W-1:0]];
      end
   end

   mlf_station_table u_station_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (st_rd_en),
      .rd_addr (cnt_ff[SIDX_W-1:0]),
      .wr      (st_wr),
      .rd_data (st_rd),
      .valid   (st_valid)
   );

   assign prdata = (paddr[2] == REG_FWD_MCAST) ? {{(PDATA_W-1){1'b0}}, fwd_mcast_ff} : '0;
   assign pready = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_forward_mask    = rsp_mask_ff;
   assign rsp_deliver_local   = rsp_dlocal_ff;
   assign rsp_unknown_dest    = rsp_unk_ff;
   assign rsp_station_learned = rsp_slearn_ff;
   assign rsp_station_full    = rsp_sfull_ff;
   assign rsp_peer_learned    = rsp_plearn_ff;
   assign rsp_peer_full       = rsp_pfull_ff;
   assign rsp_peer_slot       = rsp_pslot_ff;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mlf_pkg::*;

   localparam int LIMIT         = 1000000;
   localparam int SETTLE_CYCLES = 2 * STATION_SLOTS + 8;
   localparam int HOLD_CYCLES   = 600;
   localparam int MAC_POOL      = 80;
   localparam int IP_POOL       = PEER_SLOTS + 2;
   localparam int PHASE_ITEMS   = 130;
   localparam int PHASES        = 6;
   localparam logic [PADDR_W-1:0] FWD_MCAST_ADDR = PADDR_W'(4 * int'(REG_FWD_MCAST));

   typedef struct packed {
      logic             mode;
      logic [MAC_W-1:0] src;
      logic [MAC_W-1:0] dst;
      logic [IP_W-1:0]  ip;
   } frame_type;

   typedef struct packed {
      logic [MASK_W-1:0] forward_mask;
      logic              deliver_local;
      logic              unknown_dest;
      logic              station_learned;
      logic              station_full;
      logic              peer_learned;
      logic              peer_full;
      logic [SLOT_W-1:0] peer_slot;
   } verdict_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_mode = 1'b0;
   logic [MAC_W-1:0]    req_src_mac = '0;
   logic [MAC_W-1:0]    req_dst_mac = '0;
   logic [IP_W-1:0]     req_peer_addr = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [MASK_W-1:0]   rsp_forward_mask;
   logic                rsp_deliver_local;
   logic                rsp_unknown_dest;
   logic                rsp_station_learned;
   logic                rsp_station_full;
   logic                rsp_peer_learned;
   logic                rsp_peer_full;
   logic [SLOT_W-1:0]   rsp_peer_slot;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   // bridge tables as the block should hold them
   logic [MAC_W-1:0]    station_mac [STATION_SLOTS];
   logic                station_used [STATION_SLOTS];
   logic [LOC_W-1:0]    station_loc [STATION_SLOTS];
   logic [IP_W-1:0]     peer_ip_tab [PEER_SLOTS];
   logic                peer_used [PEER_SLOTS];
   logic                fwd_mcast = 1'b0;

   logic [MAC_W-1:0]    mac_pool [MAC_POOL];
   logic [IP_W-1:0]     ip_pool [IP_POOL];

   frame_type           pending_frames [$];
   verdict_type         expected_verdicts [$];
   frame_type           next_frame;
   verdict_type         got_verdict;
   verdict_type         exp_verdict;

   logic                req_taken = 1'b0;
   int                  req_idle_pct = 26;
   int                  rsp_idle_pct = 26;
   int                  hold_asks = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  frame_index = 0;

   mac_learning_forwarder_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_src_mac         (req_src_mac),
      .req_dst_mac         (req_dst_mac),
      .req_peer_addr       (req_peer_addr),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_forward_mask    (rsp_forward_mask),
      .rsp_deliver_local   (rsp_deliver_local),
      .rsp_unknown_dest    (rsp_unknown_dest),
      .rsp_station_learned (rsp_station_learned),
      .rsp_station_full    (rsp_station_full),
      .rsp_peer_learned    (rsp_peer_learned),
      .rsp_peer_full       (rsp_peer_full),
      .rsp_peer_slot       (rsp_peer_slot),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #4 clock = ~clock;

   function automatic logic [MAC_W-1:0] rand48();
      return MAC_W'({$urandom(), $urandom()});
   endfunction

   function automatic int station_lookup(logic [MAC_W-1:0] mac);
      for (int i = 0; i < STATION_SLOTS; i++)
         if (station_used[i] && station_mac[i] == mac) return i;
      return -1;
   endfunction

   // returns {full, learned}
   function automatic logic [1:0] station_learn(logic [MAC_W-1:0] mac, logic [LOC_W-1:0] loc);
      if (station_lookup(mac) >= 0) return 2'b00;
      for (int i = 0; i < STATION_SLOTS; i++)
         if (!station_used[i]) begin
            station_mac[i]  = mac;
            station_loc[i]  = loc;
            station_used[i] = 1'b1;
            return 2'b01;
         end
      return 2'b10;
   endfunction

   function automatic int peer_lookup(logic [IP_W-1:0] ip);
      for (int i = 0; i < PEER_SLOTS; i++)
         if (peer_used[i] && peer_ip_tab[i] == ip) return i;
      return -1;
   endfunction

   function automatic verdict_type forward_frame(frame_type f);
      verdict_type      v;
      int               p;
      int               s;
      int               d;
      logic [LOC_W-1:0] owner;
      logic [1:0]       learn;
      v = '0;
      if (f.mode) begin
         p = peer_lookup(f.ip);
         if (p < 0) begin
            for (int i = 0; i < PEER_SLOTS && p < 0; i++)
               if (!peer_used[i]) p = i;
            if (p < 0) begin
               v.peer_full = 1'b1;
            end else begin
               peer_ip_tab[p] = f.ip;
               peer_used[p]   = 1'b1;
               v.peer_learned = 1'b1;
            end
         end
         if (p >= 0) begin
            v.peer_slot = p[SLOT_W-1:0];
            learn = station_learn(f.src, p[LOC_W-1:0]);
            {v.station_full, v.station_learned} = learn;
         end
         v.deliver_local = 1'b1;
      end else begin
         learn = station_learn(f.src, LOCAL_WHERE);
         {v.station_full, v.station_learned} = learn;
         if (f.dst == BCAST_MAC || (fwd_mcast && f.dst[MAC_W-1:MAC_W-24] == MCAST_PREFIX)) begin
            s = station_lookup(f.src);
            owner = (s >= 0) ? station_loc[s] : LOCAL_WHERE;
            for (int i = 0; i < PEER_SLOTS && i < MASK_W; i++)
               if (peer_used[i] && i != owner) v.forward_mask[i] = 1'b1;
         end else begin
            d = station_lookup(f.dst);
            if (d < 0) begin
               v.unknown_dest = 1'b1;
            end else if (station_loc[d] != LOCAL_WHERE && station_loc[d] < PEER_SLOTS
                         && station_loc[d] < MASK_W) begin
               v.forward_mask[station_loc[d]] = 1'b1;
            end
         end
      end
      return v;
   endfunction

   function automatic void queue_frame(logic mode, logic [MAC_W-1:0] src,
                                       logic [MAC_W-1:0] dst, logic [IP_W-1:0] ip);
      pending_frames.push_back(frame_type'{mode, src, dst, ip});
   endfunction

   function automatic frame_type make_frame(int k);
      frame_type f;
      int        lim_mac;
      int        roll;
      lim_mac = (6 + k / 8 < MAC_POOL - 1) ? 6 + k / 8 : MAC_POOL - 1;
      f.mode = ($urandom_range(99) < 35);
      f.ip = $urandom();
      if (f.mode && $urandom_range(99) >= 3) f.ip = ip_pool[$urandom_range(IP_POOL - 1)];
      f.src = ($urandom_range(99) < 4) ? rand48() : mac_pool[$urandom_range(lim_mac)];
      roll = $urandom_range(99);
      if (roll < 20)
         f.dst = BCAST_MAC;
      else if (roll < 35)
         f.dst = {MCAST_PREFIX, 24'($urandom())};
      else if (roll < 40)
         f.dst = {MCAST_PREFIX ^ (24'd1 << $urandom_range(23)), 24'($urandom())};
      else if (roll < 90)
         f.dst = mac_pool[$urandom_range(MAC_POOL - 1)];
      else
         f.dst = rand48();
      return f;
   endfunction

   task automatic set_forward_multicast(input logic enable);
      logic [PDATA_W-1:0] readback;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= FWD_MCAST_ADDR;
      pwdata  <= PDATA_W'(enable);
      @(negedge clock) penable <= 1'b1;
      @(negedge clock);
      fwd_mcast = enable;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock) penable <= 1'b1;
      @(posedge clock) readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== PDATA_W'(enable)) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("forward_multicast readback: expected %h actual %h",
                     PDATA_W'(enable), readback);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_frames.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_frames.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            next_frame = pending_frames.pop_front();
            req_valid     <= 1'b1;
            req_mode      <= next_frame.mode;
            req_src_mac   <= next_frame.src;
            req_dst_mac   <= next_frame.dst;
            req_peer_addr <= next_frame.ip;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response backpressure, with an occasional long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // monitor: check responses, predict accepted requests
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got_verdict = {rsp_forward_mask, rsp_deliver_local, rsp_unknown_dest,
                           rsp_station_learned, rsp_station_full, rsp_peer_learned,
                           rsp_peer_full, rsp_peer_slot};
            if (expected_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected: mask=%h dl=%b ud=%b sl=%b sf=%b pl=%b pf=%b ps=%0d",
                           got_verdict.forward_mask, got_verdict.deliver_local,
                           got_verdict.unknown_dest, got_verdict.station_learned,
                           got_verdict.station_full, got_verdict.peer_learned,
                           got_verdict.peer_full, got_verdict.peer_slot);
            end else begin
               exp_verdict = expected_verdicts.pop_front();
               if (got_verdict !== exp_verdict) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("expected: mask=%h dl=%b ud=%b sl=%b sf=%b pl=%b pf=%b ps=%0d",
                              exp_verdict.forward_mask, exp_verdict.deliver_local,
                              exp_verdict.unknown_dest, exp_verdict.station_learned,
                              exp_verdict.station_full, exp_verdict.peer_learned,
                              exp_verdict.peer_full, exp_verdict.peer_slot);
                     $display("actual:   mask=%h dl=%b ud=%b sl=%b sf=%b pl=%b pf=%b ps=%0d",
                              got_verdict.forward_mask, got_verdict.deliver_local,
                              got_verdict.unknown_dest, got_verdict.station_learned,
                              got_verdict.station_full, got_verdict.peer_learned,
                              got_verdict.peer_full, got_verdict.peer_slot);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            expected_verdicts.push_back(forward_frame(frame_type'{req_mode, req_src_mac,
                                                                 req_dst_mac, req_peer_addr}));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < STATION_SLOTS; i++) station_used[i] = 1'b0;
      for (int i = 0; i < PEER_SLOTS; i++) peer_used[i] = 1'b0;
      for (int i = 0; i < MAC_POOL; i++) mac_pool[i] = rand48();
      for (int i = 0; i < IP_POOL; i++) ip_pool[i] = $urandom();
      ip_pool[0] = '0;
      ip_pool[1] = '1;

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      set_forward_multicast(1'b0);
      queue_frame(1'b0, mac_pool[0], BCAST_MAC, $urandom());
      queue_frame(1'b1, mac_pool[1], mac_pool[0], ip_pool[0]);
      queue_frame(1'b1, mac_pool[2], '0, ip_pool[1]);
      queue_frame(1'b1, mac_pool[1], BCAST_MAC, ip_pool[0]);
      queue_frame(1'b0, mac_pool[0], mac_pool[1], $urandom());
      queue_frame(1'b0, mac_pool[0], mac_pool[2], $urandom());
      queue_frame(1'b0, mac_pool[3], mac_pool[0], $urandom());
      queue_frame(1'b0, mac_pool[0], mac_pool[4], $urandom());
      queue_frame(1'b0, mac_pool[1], BCAST_MAC, $urandom());
      queue_frame(1'b0, '0, {MCAST_PREFIX, 24'h123456}, $urandom());
      queue_frame(1'b1, mac_pool[0], BCAST_MAC, ip_pool[0]);
      queue_frame(1'b1, '1, '0, ip_pool[1]);
      for (int p = 2; p < PEER_SLOTS; p++)
         queue_frame(1'b1, mac_pool[3 + p], mac_pool[0], ip_pool[p]);
      queue_frame(1'b1, mac_pool[11], mac_pool[0], ip_pool[PEER_SLOTS]);
      wait_drained();

      set_forward_multicast(1'b1);
      queue_frame(1'b0, mac_pool[0], {MCAST_PREFIX, 24'h000000}, $urandom());
      queue_frame(1'b0, mac_pool[2], {MCAST_PREFIX, 24'hFFFFFF}, $urandom());
      queue_frame(1'b0, mac_pool[0], {24'h01005F, 24'h000000}, $urandom());
      queue_frame(1'b0, mac_pool[10], BCAST_MAC, $urandom());
      queue_frame(1'b0, mac_pool[0], mac_pool[10], $urandom());
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         set_forward_multicast((ph % 2) == 0);
         req_idle_pct = (ph == 1) ? 0 : 26;
         rsp_idle_pct = (ph == 1) ? 0 : 26;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pending_frames.push_back(make_frame(frame_index));
            frame_index++;
         end
         // stall the response side while requests keep coming
         if (ph == 3) hold_asks++;
         wait_drained();
      end

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
